FILE: rtl/issd_pkg.sv
// types and constants shared by the i2c slave segment display block
`timescale 1ns / 1ps
package issd_pkg;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_ADDR  = 2'd1,
		PH_WRITE = 2'd2,
		PH_READ  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_BYTE  = 2'd1,
		MODE_ACK   = 2'd2,
		MODE_TICK  = 2'd3
	} mode_t;

	// control from the bus logic to the display part, already qualified by accept
	typedef struct packed {
		logic wr;
		logic tick;
	} disp_ctrl_t;

	localparam logic [6:0] SLAVE_ADDR_RESET = 7'd72;
	localparam logic [7:0] READ_CNT_RESET   = 8'h55;
	localparam int         RESET_DIGIT_NUM  = 4;

	localparam logic [7:0] RESET_DIGITS [RESET_DIGIT_NUM] = '{8'h3F, 8'h06, 8'h5B, 8'h4F};

	// power-up pattern of a digit, blank beyond the preset ones
	function automatic logic [7:0] digit_reset(input int idx);
		logic [7:0] val;
		val = 8'h00;
		if (idx < RESET_DIGIT_NUM) begin
			val = RESET_DIGITS[idx];
		end
		return val;
	endfunction

endpackage

FILE: rtl/i2c_slave_segment_display_top.sv
// top level: byte-level i2c slave state machine, output register and display
`timescale 1ns / 1ps
// One input word is taken per clock while s_tready is high and its result goes to the
// output register, so a steady stream runs at one word per cycle while m_tready holds.
// The output register is the only stage: s_tready is high while it is empty or being
// drained, so it follows m_tready combinationally. Every input word gives exactly one
// result word: the slave ack bit, the byte to send on a read (zero when not sending), and
// the digit position and segments currently shown by the scan. The user must write the
// slave address through cfg_we/cfg_wdata while the block is idle; it is not enforced.
module i2c_slave_segment_display_top import issd_pkg::*; #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,  // slave_address
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // rx_byte[7:0], master_nack[8], zero fill
	input  logic [1:0]  s_tuser,    // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata     // slave_ack[0], tx_valid[1], tx_byte[9:2],
	                                // digit_index[11:10], segment_pattern[19:12], zero fill
);

	localparam int               IDX_W    = $clog2(DIGIT_COUNT);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGIT_COUNT - 1);

	logic [6:0]       addr_q;
	phase_t           phase_q, phase_d;
	logic [IDX_W-1:0] bc_q, bc_d;
	logic [7:0]       rc_q, rc_d;
	logic             out_valid_q;
	logic [23:0]      out_data_q;

	logic             accept;
	mode_t            mode;
	logic [7:0]       rx_byte;
	logic             master_nack;
	logic             ack, txv;
	logic [7:0]       txb;
	disp_ctrl_t       disp_ctrl;
	logic [IDX_W-1:0] scan_next;
	logic [7:0]       seg_next;

	assign s_tready    = !out_valid_q || m_tready;
	assign accept      = s_tvalid && s_tready;
	assign mode        = mode_t'(s_tuser);
	assign rx_byte     = s_tdata[7:0];
	assign master_nack = s_tdata[8];
	assign m_tvalid    = out_valid_q;
	assign m_tdata     = out_data_q;

	always_comb begin
		phase_d   = phase_q;
		bc_d      = bc_q;
		rc_d      = rc_q;
		ack       = 1'b0;
		txv       = 1'b0;
		txb       = 8'h00;
		disp_ctrl = '0;
		case (mode)
			MODE_START: begin
				phase_d = PH_ADDR;
				bc_d    = '0;
			end
			MODE_BYTE: begin
				if (phase_q == PH_ADDR) begin
					bc_d = '0;
					if (rx_byte[7:1] == addr_q) begin
						ack = 1'b1;
						if (rx_byte[0]) begin
							phase_d = PH_READ;
							txv     = 1'b1;
							txb     = rc_q;
							rc_d    = rc_q + 8'd1;
						end else begin
							phase_d = PH_WRITE;
						end
					end else begin
						phase_d = PH_IDLE;
					end
				end else if (phase_q == PH_WRITE) begin
					disp_ctrl.wr = accept;
					// last digit is nacked and ends the transfer
					if (bc_q != LAST_IDX) begin
						ack  = 1'b1;
						bc_d = bc_q + 1'b1;
					end else begin
						phase_d = PH_IDLE;
						bc_d    = '0;
					end
				end
			end
			MODE_ACK: begin
				if (phase_q == PH_READ) begin
					if (master_nack) begin
						phase_d = PH_IDLE;
						bc_d    = '0;
					end else begin
						txv  = 1'b1;
						txb  = rc_q;
						rc_d = rc_q + 8'd1;
					end
				end
			end
			MODE_TICK: begin
				disp_ctrl.tick = accept;
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	issd_display #(
		.DIGIT_COUNT (DIGIT_COUNT),
		.IDX_W       (IDX_W)
	) u_display (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (disp_ctrl),
		.wr_addr   (bc_q),
		.wr_data   (rx_byte),
		.scan_next (scan_next),
		.seg_next  (seg_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= SLAVE_ADDR_RESET;
			phase_q     <= PH_IDLE;
			bc_q        <= '0;
			rc_q        <= READ_CNT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				addr_q <= cfg_wdata;
			end
			if (accept) begin
				phase_q     <= phase_d;
				bc_q        <= bc_d;
				rc_q        <= rc_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {4'h0, seg_next, 2'(scan_next), txb, txv, ack};
		end
	end

	a_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[1] |-> m_tdata[9:2] == 8'h00)
		else $error("tx byte not zero while no byte is sent");

	a_start_addr: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode == MODE_START |=> phase_q == PH_ADDR && bc_q == '0)
		else $error("start event did not arm address phase");

	a_bc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_WRITE |-> bc_q == '0)
		else $error("byte count nonzero outside write phase");

	a_rc_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && txv |=> rc_q == $past(rc_q) + 8'd1)
		else $error("read counter did not advance with a sent byte");

	a_ack_excl: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ack |-> mode == MODE_BYTE)
		else $error("ack given for a word that is not a received byte");

endmodule

FILE: rtl/issd_display.sv
// digit store and multiplex scan of the segment display
`timescale 1ns / 1ps
module issd_display import issd_pkg::*; #(
	parameter int DIGIT_COUNT = 4,
	parameter int IDX_W       = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  disp_ctrl_t       ctrl,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [7:0]       wr_data,
	output logic [IDX_W-1:0] scan_next,
	output logic [7:0]       seg_next
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGIT_COUNT - 1);

	logic [7:0]       digit_q [DIGIT_COUNT];
	logic [IDX_W-1:0] scan_q;

	always_comb begin
		scan_next = scan_q;
		if (ctrl.tick) begin
			scan_next = (scan_q == LAST_IDX) ? '0 : scan_q + 1'b1;
		end
		// a word written this cycle shows at once if it is the scanned digit
		if (ctrl.wr && wr_addr == scan_next) begin
			seg_next = wr_data;
		end else begin
			seg_next = digit_q[scan_next];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				digit_q[i] <= digit_reset(i);
			end
		end else begin
			scan_q <= scan_next;
			if (ctrl.wr) begin
				digit_q[wr_addr] <= wr_data;
			end
		end
	end

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q <= LAST_IDX)
		else $error("scan index beyond last digit");

	a_scan_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.tick |=> $stable(scan_q))
		else $error("scan moved without a refresh tick");

	a_wr_tick_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.wr && ctrl.tick))
		else $error("digit write and refresh tick in the same word");

endmodule
